/* rtl/core/tpe_pkg.sv */
package tpe_pkg;

    localparam int DEF_MAX_TERMS = 32;
    localparam int DEF_EXP_BITS  = 4;

    // Command codes of the input transaction
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_EVAL   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] coeff;
        logic [3:0]         exp_x;
        logic [3:0]         exp_y;
        logic [3:0]         exp_z;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] z_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] poly_value;
        logic               status;
        logic [5:0]         term_total;
    } result_t;

    // Microcode
    localparam int STEP_W = 3;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_INIT = 3'd1,
        OP_LOAD = 3'd2,
        OP_MUL  = 3'd3,
        OP_SQR  = 3'd4,
        OP_NVAR = 3'd5,
        OP_ACC  = 3'd6,
        OP_DONE = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_EMPTY    = 3'd1,
        J_MORE_BIT = 3'd2,
        J_MORE_VAR = 3'd3,
        J_MORE_TRM = 3'd4,
        J_OUT_BUSY = 3'd5
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    localparam logic [STEP_W-1:0] ST_INIT = 3'd0;
    localparam logic [STEP_W-1:0] ST_READ = 3'd1;
    localparam logic [STEP_W-1:0] ST_LOAD = 3'd2;
    localparam logic [STEP_W-1:0] ST_MUL  = 3'd3;
    localparam logic [STEP_W-1:0] ST_SQR  = 3'd4;
    localparam logic [STEP_W-1:0] ST_NVAR = 3'd5;
    localparam logic [STEP_W-1:0] ST_ACC  = 3'd6;
    localparam logic [STEP_W-1:0] ST_DONE = 3'd7;

    // Evaluate program: square-and-multiply per variable, at most one product per step
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{op: OP_NONE, cond: J_NEXT, target: ST_INIT};
        case (step)
            ST_INIT: w = '{op: OP_INIT, cond: J_EMPTY,    target: ST_DONE};
            ST_READ: w = '{op: OP_NONE, cond: J_NEXT,     target: ST_INIT};
            ST_LOAD: w = '{op: OP_LOAD, cond: J_NEXT,     target: ST_INIT};
            ST_MUL:  w = '{op: OP_MUL,  cond: J_NEXT,     target: ST_INIT};
            ST_SQR:  w = '{op: OP_SQR,  cond: J_MORE_BIT, target: ST_MUL};
            ST_NVAR: w = '{op: OP_NVAR, cond: J_MORE_VAR, target: ST_MUL};
            ST_ACC:  w = '{op: OP_ACC,  cond: J_MORE_TRM, target: ST_READ};
            ST_DONE: w = '{op: OP_DONE, cond: J_OUT_BUSY, target: ST_DONE};
            default: w = '{op: OP_NONE, cond: J_NEXT,     target: ST_INIT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/tpe_ram.sv */
module tpe_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/trivariate_polynomial_evaluator.sv */
// Trivariate polynomial evaluator. The block holds a table of up to MAX_TERMS
// terms (signed 16-bit coefficient, exponents of EXP_BITS bits for x, y, z) in
// a single-port-write, registered-read RAM. An append transaction stores one
// term (a zero coefficient stores nothing; a nonzero one into a full table is
// dropped with status 1), a clear transaction empties the table, and command
// 3 changes nothing; each returns poly_value 0. An evaluate transaction runs a
// short microcode program that walks the table in order and raises x, y and z
// to each term's powers by square-and-multiply on one shared 32x32 multiplier,
// summing modulo 2^32. Per term the program runs one RAM read step, a load,
// a multiply and a squaring step for every exponent bit of every variable,
// one step to move on after each of the three variables and one accumulate
// step, all through the single multiplier; an init and a done step frame the
// walk. The input is stalled while an evaluate runs. A finished result sits
// in an output register; the input is also stalled while that result waits,
// and the next transaction is taken in the cycle that the result is accepted.
module trivariate_polynomial_evaluator #(
    parameter int MAX_TERMS = tpe_pkg::DEF_MAX_TERMS,
    parameter int EXP_BITS  = tpe_pkg::DEF_EXP_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tpe_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tpe_pkg::result_t result
);

    import tpe_pkg::*;

    localparam int AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW   = $clog2(MAX_TERMS + 1);
    localparam int BW   = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam int RAMW = 16 + 3 * EXP_BITS;

    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TERMS);
    localparam logic [BW-1:0] LAST_BIT   = BW'(EXP_BITS - 1);

    // Variable being raised
    localparam logic [1:0] VAR_X = 2'd0;
    localparam logic [1:0] VAR_Y = 2'd1;
    localparam logic [1:0] VAR_Z = 2'd2;

    // Control state
    logic              busy_reg,      busy_next;
    logic [STEP_W-1:0] step_reg,      step_next;
    logic [CW-1:0]     count_reg,     count_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath state
    result_t             out_data_reg, out_data_next;
    logic [31:0]         acc_reg,  acc_next;
    logic [31:0]         term_reg, term_next;
    logic [31:0]         pow_reg,  pow_next;
    logic [BW-1:0]       bit_reg,  bit_next;
    logic [1:0]          var_reg,  var_next;
    logic [CW-1:0]       idx_reg,  idx_next;
    logic [3*EXP_BITS-1:0] exps_reg, exps_next;
    logic [31:0]         x_reg, x_next;
    logic [31:0]         y_reg, y_next;
    logic [31:0]         z_reg, z_next;

    uword_t            uword;
    logic              slot_free;
    logic              accept;
    logic              jump;
    logic              full;
    logic              ram_we;
    logic [RAMW-1:0]   ram_wdata;
    logic [RAMW-1:0]   ram_rdata;
    logic [EXP_BITS-1:0] cur_exp;
    logic [31:0]       mul_a;
    logic [31:0]       mul_p;

    tpe_ram #(
        .WIDTH (RAMW),
        .DEPTH (MAX_TERMS)
    ) u_terms (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign uword     = ucode_rom(step_reg);
    assign slot_free = !out_valid_reg || !result_stall;
    assign item_stall = busy_reg || !slot_free;
    assign accept    = item_valid && !item_stall;
    assign full      = (count_reg == FULL_COUNT);

    assign ram_we    = accept && (item.cmd == CMD_APPEND) && (item.coeff != 16'sd0) && !full;
    assign ram_wdata = {EXP_BITS'(item.exp_z), EXP_BITS'(item.exp_y),
                        EXP_BITS'(item.exp_x), item.coeff};

    // Exponent of the variable in progress
    always_comb
    begin
        case (var_reg)
            VAR_X:   cur_exp = exps_reg[0 +: EXP_BITS];
            VAR_Y:   cur_exp = exps_reg[EXP_BITS +: EXP_BITS];
            default: cur_exp = exps_reg[2*EXP_BITS +: EXP_BITS];
        endcase
    end

    // One shared multiplier, low 32 bits of the product
    assign mul_a = (uword.op == OP_MUL) ? term_reg : pow_reg;
    assign mul_p = mul_a * pow_reg;

    // Sequencer branch
    always_comb
    begin
        case (uword.cond)
            J_NEXT:     jump = 1'b0;
            J_EMPTY:    jump = (count_reg == '0);
            J_MORE_BIT: jump = (bit_reg != LAST_BIT);
            J_MORE_VAR: jump = (var_reg != VAR_Z);
            J_MORE_TRM: jump = ({1'b0, idx_reg} + (CW+1)'(1)) < {1'b0, count_reg};
            J_OUT_BUSY: jump = !slot_free;
            default:    jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        acc_next       = acc_reg;
        term_next      = term_reg;
        pow_next       = pow_reg;
        bit_next       = bit_reg;
        var_next       = var_reg;
        idx_next       = idx_reg;
        exps_next      = exps_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;

        if (accept)
        begin
            case (item.cmd)
                CMD_APPEND:
                begin
                    out_data_next.status = 1'b0;
                    if (item.coeff != 16'sd0)
                    begin
                        if (full)
                        begin
                            out_data_next.status = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    out_data_next.poly_value = '0;
                    out_data_next.term_total = 6'(count_next);
                    out_valid_next           = 1'b1;
                end
                CMD_EVAL:
                begin
                    // Hold the point and start the program
                    busy_next = 1'b1;
                    step_next = ST_INIT;
                    x_next    = {{16{item.x_value[15]}}, item.x_value};
                    y_next    = {{16{item.y_value[15]}}, item.y_value};
                    z_next    = {{16{item.z_value[15]}}, item.z_value};
                end
                CMD_CLEAR:
                begin
                    count_next               = '0;
                    out_data_next.poly_value = '0;
                    out_data_next.status     = 1'b0;
                    out_data_next.term_total = '0;
                    out_valid_next           = 1'b1;
                end
                default:
                begin
                    out_data_next.poly_value = '0;
                    out_data_next.status     = 1'b0;
                    out_data_next.term_total = 6'(count_reg);
                    out_valid_next           = 1'b1;
                end
            endcase
        end

        if (busy_reg)
        begin
            step_next = jump ? uword.target : step_reg + STEP_W'(1);
            case (uword.op)
                OP_INIT:
                begin
                    acc_next = '0;
                    idx_next = '0;
                end
                OP_LOAD:
                begin
                    term_next = {{16{ram_rdata[15]}}, ram_rdata[15:0]};
                    exps_next = ram_rdata[16 +: 3*EXP_BITS];
                    pow_next  = x_reg;
                    var_next  = VAR_X;
                    bit_next  = '0;
                end
                OP_MUL:
                begin
                    if (cur_exp[bit_reg])
                    begin
                        term_next = mul_p;
                    end
                end
                OP_SQR:
                begin
                    pow_next = mul_p;
                    if (bit_reg != LAST_BIT)
                    begin
                        bit_next = bit_reg + BW'(1);
                    end
                end
                OP_NVAR:
                begin
                    bit_next = '0;
                    if (var_reg != VAR_Z)
                    begin
                        var_next = var_reg + 2'd1;
                        pow_next = (var_reg == VAR_X) ? y_reg : z_reg;
                    end
                end
                OP_ACC:
                begin
                    acc_next = acc_reg + term_reg;
                    idx_next = idx_reg + CW'(1);
                end
                OP_DONE:
                begin
                    if (slot_free)
                    begin
                        busy_next                = 1'b0;
                        out_valid_next           = 1'b1;
                        out_data_next.poly_value = acc_reg;
                        out_data_next.status     = 1'b0;
                        out_data_next.term_total = 6'(count_reg);
                    end
                end
                default:
                begin
                    // Wait for the RAM read
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= ST_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        acc_reg      <= acc_next;
        term_reg     <= term_next;
        pow_reg      <= pow_next;
        bit_reg      <= bit_next;
        var_reg      <= var_next;
        idx_reg      <= idx_next;
        exps_reg     <= exps_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    // The table never holds more terms than it has entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("term count beyond table depth");

    // The table is frozen while an evaluation walks it
    a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> $stable(count_reg))
        else $error("term count changed during evaluate");

    // A finished evaluation shows up in the output register
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && uword.op == OP_DONE && slot_free) |=> (out_valid_reg && !busy_reg))
        else $error("evaluate result not delivered");

    // A drop is only reported with a full table
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status) |-> (out_data_reg.term_total == 6'(MAX_TERMS)))
        else $error("drop reported with table not full");
`endif

endmodule
